[hdl/hapll_pkg.sv]
// Shared types, constants and functions of the HFI angle tracking PLL.
// Holds the quarter-wave sine table, which is built at elaboration.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hapll_pkg;

    // Sine table and phase geometry.
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int ANGLE_BITS       = 16;
    localparam int QB               = ANGLE_BITS - 2;
    localparam int TBL_AW           = $clog2(SINE_TABLE_DEPTH);
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IDXP_W           = QB + IDX_W;

    // Field widths.
    localparam int CUR_W   = 16;
    localparam int DIR_W   = 2;
    localparam int ANG_W   = 16;
    localparam int SPD_W   = 32;
    localparam int GAIN_W  = 16;
    localparam int TIME_W  = 32;
    localparam int ERR_W   = 18;
    localparam int ACC_W   = 32;
    localparam int SAT_W   = 36;
    localparam int HK_W    = 44;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME     = 2'd2;

    // Arithmetic constants.
    localparam logic [63:0]        HALF_PI_Q30    = 64'd1686629713;
    localparam logic [29:0]        INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [ACC_W-1:0]   HALF_TURN      = 32'h8000_0000;
    localparam logic [14:0]        SINE_MAX       = 15'h7FFF;
    localparam logic [63:0]        TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integral_gain;
        logic [TIME_W-1:0] step_time_q32;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        prop_gain:     16'd550,
        integral_gain: 16'd9000,
        step_time_q32: 32'd214748
    };

    typedef logic [14:0] t_sine_tbl [SINE_TABLE_DEPTH];

    // One table entry: sin(k*pi/(2*depth)) from a Q2.30 Taylor series, scaled to Q1.15.
    function automatic logic [14:0] sine_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic [63:0]        v;
        int                 n;
        x   = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        mag = x;
        sum = signed'(x);
        for (n = 1; n <= 5; n++) begin
            mag = (mag * x) >> 30;
            mag = (mag * x) >> 30;
            mag = mag / TAYLOR_DIV[n-1];
            if (n[0]) begin
                sum = sum - signed'(mag);
            end else begin
                sum = sum + signed'(mag);
            end
        end
        if (sum <= 0) begin
            return 15'd0;
        end
        v = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            return SINE_MAX;
        end
        return v[14:0];
    endfunction

    function automatic t_sine_tbl build_sine_tbl();
        t_sine_tbl   t;
        int unsigned k;
        for (k = 0; k < SINE_TABLE_DEPTH; k++) begin
            t[k] = sine_entry(k);
        end
        return t;
    endfunction

    localparam t_sine_tbl SINE_TBL = build_sine_tbl();

    // Full-wave sine from the quarter-wave table; the entry one past the end reads as full scale.
    function automatic logic signed [15:0] sine_wave(input logic [1:0] quad,
                                                     input logic [TBL_AW-1:0] idx);
        logic [IDX_W-1:0] i;
        logic [14:0]      m;
        i = quad[0] ? (IDX_W'(SINE_TABLE_DEPTH) - IDX_W'(idx)) : IDX_W'(idx);
        if (i >= IDX_W'(SINE_TABLE_DEPTH)) begin
            m = SINE_MAX;
        end else begin
            m = SINE_TBL[i[TBL_AW-1:0]];
        end
        return quad[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        if ((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31])) begin
            return v[31:0];
        end
        return v[SAT_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

endpackage

`default_nettype wire

[hdl/hapll_if.sv]
// Valid/ready channel interfaces of the HFI angle tracking PLL:
// input item, result item and configuration write.
// Depends on hapll_pkg for the field widths.
`default_nettype none

interface hapll_in_if import hapll_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [CUR_W-1:0] hf_current_alpha;
    logic signed [CUR_W-1:0] hf_current_beta;
    logic signed [DIR_W-1:0] speed_direction;
    logic                    polarity_flip;

    modport source (output valid, hf_current_alpha, hf_current_beta, speed_direction,
                    polarity_flip, input ready);
    modport sink   (input valid, hf_current_alpha, hf_current_beta, speed_direction,
                    polarity_flip, output ready);
endinterface

interface hapll_out_if import hapll_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ANG_W-1:0]        rotor_angle;
    logic signed [SPD_W-1:0] rotor_speed;

    modport source (output valid, rotor_angle, rotor_speed, input ready);
    modport sink   (input valid, rotor_angle, rotor_speed, output ready);
endinterface

interface hapll_cfg_if import hapll_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/hapll_cfg.sv]
// Configuration register file of the HFI angle tracking PLL: gains and control period.
// Depends on hapll_pkg and the hapll_cfg_if interface.
`default_nettype none

module hapll_cfg import hapll_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hapll_cfg_if.sink    i_cfg,
    output t_cfg         o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken; an index past the register list is dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_PROP_GAIN:     r_cfg.prop_gain     <= i_cfg.data[GAIN_W-1:0];
                REG_INTEGRAL_GAIN: r_cfg.integral_gain <= i_cfg.data[GAIN_W-1:0];
                REG_STEP_TIME:     r_cfg.step_time_q32 <= i_cfg.data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hdl/hfi_angle_tracking_pll_core.sv]
// HFI angle tracking PLL, top level. One shared 34x33 multiplier under a sequencer.
// The input is ready only while the sequencer is idle, so a new item is taken only after the
// result of the last one has been loaded into the output register.
// Reset (i_rst_n low, synchronous) clears integrator, angle and the output valid flag,
// and loads the default gains and period. Depends on hapll_pkg, hapll_if, hapll_cfg.
`default_nettype none

module hfi_angle_tracking_pll_core import hapll_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hapll_in_if.sink     i_in,
    hapll_out_if.source  o_out,
    hapll_cfg_if.sink    i_cfg
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SIN  = 4'd1;
    localparam logic [3:0] ST_COS  = 4'd2;
    localparam logic [3:0] ST_E1   = 4'd3;
    localparam logic [3:0] ST_E2   = 4'd4;
    localparam logic [3:0] ST_P    = 4'd5;
    localparam logic [3:0] ST_SPD  = 4'd6;
    localparam logic [3:0] ST_I1   = 4'd7;
    localparam logic [3:0] ST_I2   = 4'd8;
    localparam logic [3:0] ST_A1   = 4'd9;
    localparam logic [3:0] ST_A2   = 4'd10;
    localparam logic [3:0] ST_A3   = 4'd11;

    t_cfg cfg;

    hapll_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    logic [3:0]                r_state, n_state;
    logic signed [CUR_W-1:0]   r_ia, r_ib;
    logic [DIR_W-1:0]          r_dir;
    logic                      r_flip;
    logic signed [15:0]        r_sin, r_cos;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [32:0]        r_acc;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [SPD_W-1:0]   r_speed;
    logic signed [ACC_W-1:0]   r_int;
    logic [ACC_W-1:0]          r_angle;
    logic [31:0]               r_lo;
    logic [HK_W-1:0]           r_hk;
    logic                      r_ovalid;
    logic [ANG_W-1:0]          r_o_angle;
    logic signed [SPD_W-1:0]   r_o_speed;

    logic                      in_xfer, out_free;
    logic [ANGLE_BITS-1:0]     phase;
    logic [1:0]                quad, wave_quad;
    logic [QB-1:0]             rest;
    logic [IDXP_W-1:0]         idx_prod;
    logic [TBL_AW-1:0]         idx;
    logic signed [15:0]        wave_val;
    logic signed [MUL_A_W-1:0] m_a;
    logic signed [MUL_B_W-1:0] m_b;
    logic signed [PROD_W-1:0]  mul_res;
    logic signed [32:0]        e_sum;
    logic signed [34:0]        spd_sum;
    logic signed [SPD_W-1:0]   spd_sat, spd_forced;
    logic signed [ERR_W-1:0]   err_neg;
    logic [ERR_W-2:0]          err_mag;
    logic [64:0]               inc_sum;
    logic [32:0]               inc;
    logic signed [SAT_W-1:0]   int_sum;
    logic signed [32:0]        spd_ext, spd_neg;
    logic [31:0]               speed_mag;
    logic [HK_W-1:0]           ang_sum;
    logic [ACC_W-1:0]          d_mag, delta, n_angle;

    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_free   = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // Phase to quadrant and table index.
    assign phase     = r_angle[ACC_W-1 -: ANGLE_BITS];
    assign quad      = phase[ANGLE_BITS-1 -: 2];
    assign rest      = phase[QB-1:0];
    assign idx_prod  = IDXP_W'(rest) * IDXP_W'(SINE_TABLE_DEPTH);
    assign idx       = idx_prod[QB +: TBL_AW];
    // The cosine is the sine one quadrant ahead.
    assign wave_quad = (r_state == ST_COS) ? quad + 2'd1 : quad;
    assign wave_val  = sine_wave(wave_quad, idx);

    // Error sum; the arithmetic shift floors toward minus infinity.
    assign e_sum = r_acc + r_prod[32:0];

    assign spd_sum = 35'(signed'(r_prod[33:0])) + 35'(r_int);
    assign spd_sat = sat32(SAT_W'(spd_sum));

    always_comb begin
        spd_forced = spd_sat;
        if (r_dir == 2'b01 && spd_sat[SPD_W-1]) begin
            spd_forced = (spd_sat == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -spd_sat;
        end else if (r_dir[1] && !spd_sat[SPD_W-1] && (spd_sat != 32'sd0)) begin
            spd_forced = -spd_sat;
        end
    end

    assign err_neg = -r_err;
    assign err_mag = r_err[ERR_W-1] ? err_neg[ERR_W-2:0] : r_err[ERR_W-2:0];

    // Integrator step rounded half up from the 2^-32 scaled product.
    assign inc_sum = {1'b0, r_prod[63:0]} + 65'h0_8000_0000;
    assign inc     = inc_sum[64:32];
    assign int_sum = r_err[ERR_W-1] ? (SAT_W'(r_int) - SAT_W'(inc))
                                    : (SAT_W'(r_int) + SAT_W'(inc));

    assign spd_ext   = 33'(r_speed);
    assign spd_neg   = -spd_ext;
    assign speed_mag = r_speed[SPD_W-1] ? spd_neg[31:0] : spd_ext[31:0];

    // Angle step: high partial product plus rounding plus the carry-in of the low one.
    assign ang_sum = r_hk + HK_W'(r_prod[63:32]);
    assign d_mag   = ang_sum[HK_W-1:12];
    assign delta   = r_speed[SPD_W-1] ? (32'd0 - d_mag) : d_mag;
    assign n_angle = r_angle + delta + (r_flip ? (delta + HALF_TURN) : 32'd0);

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_state)
            ST_COS: begin
                m_a = MUL_A_W'(r_ia);
                m_b = MUL_B_W'(r_sin);
            end
            ST_E1: begin
                m_a = MUL_A_W'(r_ib);
                m_b = MUL_B_W'(r_cos);
            end
            ST_P: begin
                m_a = signed'(MUL_A_W'(cfg.prop_gain));
                m_b = MUL_B_W'(r_err);
            end
            ST_SPD: begin
                m_a = signed'(MUL_A_W'(cfg.integral_gain));
                m_b = signed'(MUL_B_W'(err_mag));
            end
            ST_I1: begin
                m_a = signed'(MUL_A_W'(r_prod[32:0]));
                m_b = signed'(MUL_B_W'(cfg.step_time_q32));
            end
            ST_I2: begin
                m_a = signed'(MUL_A_W'(speed_mag));
                m_b = signed'(MUL_B_W'(cfg.step_time_q32));
            end
            ST_A1: begin
                m_a = signed'(MUL_A_W'(r_prod[63:32]));
                m_b = signed'(MUL_B_W'(INV_TWO_PI_Q32));
            end
            ST_A2: begin
                m_a = signed'(MUL_A_W'(r_lo));
                m_b = signed'(MUL_B_W'(INV_TWO_PI_Q32));
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign mul_res = m_a * m_b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_xfer) begin
                n_state = ST_SIN;
            end
            ST_SIN:  n_state = ST_COS;
            ST_COS:  n_state = ST_E1;
            ST_E1:   n_state = ST_E2;
            ST_E2:   n_state = ST_P;
            ST_P:    n_state = ST_SPD;
            ST_SPD:  n_state = ST_I1;
            ST_I1:   n_state = ST_I2;
            ST_I2:   n_state = ST_A1;
            ST_A1:   n_state = ST_A2;
            ST_A2:   n_state = ST_A3;
            ST_A3: if (out_free) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_int    <= '0;
            r_angle  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_I2) begin
                r_int <= sat32(int_sum);
            end
            if (r_state == ST_A3 && out_free) begin
                r_angle  <= n_angle;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // The low partial product is held while the result waits for the output register.
        if (r_state != ST_A3) begin
            r_prod <= mul_res;
        end
        if (in_xfer) begin
            r_ia   <= i_in.hf_current_alpha;
            r_ib   <= i_in.hf_current_beta;
            r_dir  <= i_in.speed_direction;
            r_flip <= i_in.polarity_flip;
        end
        if (r_state == ST_SIN) begin
            r_sin <= wave_val;
        end
        if (r_state == ST_COS) begin
            r_cos <= wave_val;
        end
        if (r_state == ST_E1) begin
            r_acc <= -r_prod[32:0];
        end
        if (r_state == ST_E2) begin
            r_err <= e_sum[32:15];
        end
        if (r_state == ST_SPD) begin
            r_speed <= spd_forced;
        end
        if (r_state == ST_A1) begin
            r_lo <= r_prod[31:0];
        end
        if (r_state == ST_A2) begin
            r_hk <= r_prod[HK_W-1:0] + HK_W'(2048);
        end
        if (r_state == ST_A3 && out_free) begin
            r_o_angle <= n_angle[ACC_W-1 -: ANG_W];
            r_o_speed <= r_speed;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.rotor_angle = r_o_angle;
    assign o_out.rotor_speed = r_o_speed;

endmodule

`default_nettype wire

[hdl/hapll_checker.sv]
// Port-level checks of the HFI angle tracking PLL, bound to the top level.
// Depends on hapll_pkg for field widths.
`default_nettype none

module hapll_checker import hapll_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [ANG_W-1:0]        i_rotor_angle,
    input logic signed [SPD_W-1:0] i_rotor_speed
);

    // An accepted item keeps the block busy in the following cycle.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an input transfer");

    // A result cannot appear in the cycle after an input transfer.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after input transfer");

    // A new result only comes out of a computation, never while the input was open.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared while the block was idle");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_rotor_angle) && $stable(i_rotor_speed)))
        else $error("stalled result changed or dropped");

endmodule

bind hfi_angle_tracking_pll_core hapll_checker u_hapll_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_rotor_angle (o_out.rotor_angle),
    .i_rotor_speed (o_out.rotor_speed)
);

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench of hfi_angle_tracking_pll_core: directed and random current samples,
// with the tracked angle and speed predicted alongside the block and compared per transfer.
// Depends on hapll_pkg, the channel interfaces in hapll_if and the core RTL.

module testbench import hapll_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LUT_DEPTH         = 256;
    localparam int          LUT_AW            = $clog2(LUT_DEPTH);
    localparam int          PHASE_BITS        = 16;
    localparam logic [63:0] QUARTER_TURN_Q30  = 64'd1686629713;
    localparam logic [63:0] TURN_PER_RAD_Q32  = 64'd683565276;
    localparam logic [31:0] HALF_REV          = 32'h8000_0000;
    localparam int          S32_MAX           = 32'sh7FFF_FFFF;
    localparam int          S32_MIN           = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [DIR_W-1:0] DIR_NONE    = 2'b00;
    localparam logic [DIR_W-1:0] DIR_FWD     = 2'b01;
    localparam logic [DIR_W-1:0] DIR_REV     = 2'b11;
    localparam logic [DIR_W-1:0] DIR_REV_ALT = 2'b10;

    localparam int RANDOM_PHASES     = 6;
    localparam int LONG_STALL_AT     = 150;
    localparam int LONG_STALL_CYCLES = 400;
    localparam int DRAIN_AT          = 450;
    localparam int MAX_REPORTS       = 50;
    localparam int RUN_LIMIT_NS      = 1_000_000;

    typedef struct packed {
        logic [CUR_W-1:0] alpha;
        logic [CUR_W-1:0] beta;
        logic [DIR_W-1:0] dir;
        logic             flip;
    } t_hf_sample;

    typedef struct packed {
        logic [ANG_W-1:0]        angle;
        logic signed [SPD_W-1:0] speed;
    } t_rotor_estimate;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} t_ready_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hapll_in_if  hf_in ();
    hapll_out_if est_out ();
    hapll_cfg_if reg_wr ();

    hfi_angle_tracking_pll_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (hf_in),
        .o_out   (est_out),
        .i_cfg   (reg_wr)
    );

    // Observer state and register copies.
    logic [GAIN_W-1:0] obs_kp       = 16'd550;
    logic [GAIN_W-1:0] obs_ki       = 16'd9000;
    logic [TIME_W-1:0] obs_period   = 32'd214748;
    int                obs_integrator = 0;
    logic [31:0]       obs_angle    = '0;
    logic [14:0]       sine_lut [LUT_DEPTH];

    t_hf_sample      hf_samples[$];
    t_rotor_estimate expected_estimates[$];

    int          items_accepted = 0;
    int          results_seen   = 0;
    int          mismatch_count = 0;
    int          gap_left       = 0;
    int          burst_left     = 0;
    logic        drain_done     = 1'b0;
    int          stall_left     = 0;
    int          mode_left      = 0;
    t_ready_mode ready_mode     = RDY_ALWAYS;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Quarter-wave table from an eleventh-order Taylor series in Q2.30, scaled to Q1.15.
    initial begin : fill_sine_lut
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] series;
        logic [63:0]        scaled;
        for (int k = 0; k < LUT_DEPTH; k++) begin
            x      = (64'(k) * QUARTER_TURN_Q30) / 64'(LUT_DEPTH);
            term   = x;
            series = signed'(x);
            for (int n = 1; n <= 5; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                series = (n % 2 == 1) ? series - signed'(term) : series + signed'(term);
            end
            if (series <= 0) begin
                sine_lut[k] = '0;
            end else begin
                scaled = (64'(series) * 64'd32767 + (64'd1 << 29)) >> 30;
                sine_lut[k] = (scaled > 64'd32767) ? 15'h7FFF : scaled[14:0];
            end
        end
    end

    function automatic int clamp_s32(input longint v);
        if (v > S32_MAX) begin
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            return S32_MIN;
        end
        return int'(v);
    endfunction

    // Mirrored quadrants read the table backwards; one past the end is full scale.
    function automatic logic signed [16:0] lut_wave(input logic [1:0] quad,
                                                    input logic [LUT_AW-1:0] idx);
        int                 pos;
        logic signed [16:0] m;
        pos = quad[0] ? LUT_DEPTH - int'(idx) : int'(idx);
        m   = (pos >= LUT_DEPTH) ? 17'sd32767 : $signed({2'b00, sine_lut[pos]});
        return quad[1] ? -m : m;
    endfunction

    function automatic void advance_observer(input t_hf_sample smp);
        logic [PHASE_BITS-1:0] phase;
        logic [1:0]            quad;
        logic [PHASE_BITS-3:0] rest;
        logic [LUT_AW-1:0]     idx;
        longint                s;
        longint                c;
        longint                e;
        longint                err;
        longint                inc;
        int                    speed;
        logic [127:0]          prod;
        logic [63:0]           mag;
        logic [63:0]           d;
        logic [31:0]           delta;
        t_rotor_estimate       est;
        phase = obs_angle[31 -: PHASE_BITS];
        quad  = phase[PHASE_BITS-1 -: 2];
        rest  = phase[PHASE_BITS-3:0];
        idx   = LUT_AW'((64'(rest) * 64'(LUT_DEPTH)) >> (PHASE_BITS - 2));
        s     = lut_wave(quad, idx);
        c     = lut_wave(quad + 2'd1, idx);
        e     = -longint'($signed(smp.alpha)) * s + longint'($signed(smp.beta)) * c;
        err   = e >>> 15;

        speed = clamp_s32($signed(64'(obs_kp)) * err + longint'(obs_integrator));
        if (smp.dir == DIR_FWD && speed < 0) begin
            speed = (speed == S32_MIN) ? S32_MAX : -speed;
        end else if (smp.dir[1] && speed > 0) begin
            speed = -speed;
        end

        mag  = (err < 0) ? 64'(-err) : 64'(err);
        prod = 128'(obs_ki) * 128'(mag) * 128'(obs_period);
        inc  = longint'((prod + (128'd1 << 31)) >> 32);
        obs_integrator = clamp_s32((err < 0) ? longint'(obs_integrator) - inc
                                             : longint'(obs_integrator) + inc);

        // The angle step is |speed|*T/(2*pi) in turn units, rounded and given the speed's sign.
        mag  = (speed < 0) ? 64'(-longint'(speed)) : 64'(speed);
        prod = 128'(mag) * 128'(obs_period);
        d    = 64'((128'(prod[63:32]) * 128'(TURN_PER_RAD_Q32) + 128'd2048
                    + ((128'(prod[31:0]) * 128'(TURN_PER_RAD_Q32)) >> 32)) >> 12);
        delta = d[31:0];
        if (speed < 0) begin
            delta = -delta;
        end
        obs_angle = obs_angle + delta;
        if (smp.flip) begin
            obs_angle = obs_angle + delta + HALF_REV;
        end

        est.angle = obs_angle[31:16];
        est.speed = speed;
        expected_estimates.push_back(est);
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic void add_sample(input int alpha, input int beta,
                                       input logic [DIR_W-1:0] dir, input logic flip);
        t_hf_sample smp;
        smp.alpha = alpha[CUR_W-1:0];
        smp.beta  = beta[CUR_W-1:0];
        smp.dir   = dir;
        smp.flip  = flip;
        hf_samples.push_back(smp);
    endfunction

    function automatic int pick_current();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return int'($urandom_range(0, 65535)) - 32768;
            6, 7, 8:          return int'($urandom_range(0, 4095)) - 2048;
            default: begin
                case ($urandom_range(0, 2))
                    0:       return -32768;
                    1:       return 32767;
                    default: return 0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom());
            default: return GAIN_W'($urandom_range(100, 12000));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        reg_wr.valid <= 1'b1;
        reg_wr.index <= idx;
        reg_wr.data  <= value;
        do @(posedge i_clk); while (!reg_wr.ready);
        reg_wr.valid <= 1'b0;
        case (idx)
            REG_PROP_GAIN:     obs_kp = value[GAIN_W-1:0];
            REG_INTEGRAL_GAIN: obs_ki = value[GAIN_W-1:0];
            REG_STEP_TIME:     obs_period = value[TIME_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (hf_samples.size() != 0 || items_accepted != results_seen) begin
            @(negedge i_clk);
        end
    endtask

    // Sample driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin : drive_samples
        t_hf_sample cur;
        int         taken;
        logic       hold;
        taken = items_accepted;
        hold  = 1'b0;
        if (!i_rst_n) begin
            hf_in.valid <= 1'b0;
        end else begin
            if (hf_in.valid && hf_in.ready) begin
                cur = hf_samples.pop_front();
                advance_observer(cur);
                taken++;
                items_accepted <= taken;
            end
            // Once in the run, hold back mid-phase until every estimate has been delivered.
            if (!drain_done && taken >= DRAIN_AT && hf_samples.size() != 0) begin
                drain_done = (results_seen == taken);
                hold       = !drain_done;
            end
            if (!hf_in.valid || hf_in.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    hf_in.valid <= 1'b0;
                end else if (hold || hf_samples.size() == 0) begin
                    hf_in.valid <= 1'b0;
                end else begin
                    hf_in.valid            <= 1'b1;
                    hf_in.hf_current_alpha <= hf_samples[0].alpha;
                    hf_in.hf_current_beta  <= hf_samples[0].beta;
                    hf_in.speed_direction  <= hf_samples[0].dir;
                    hf_in.polarity_flip    <= hf_samples[0].flip;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // Estimate monitor and receiver back-pressure.
    always @(posedge i_clk) begin : check_estimates
        t_rotor_estimate want;
        if (!i_rst_n) begin
            est_out.ready <= 1'b0;
        end else begin
            if (est_out.valid && est_out.ready) begin
                if (results_seen == items_accepted) begin
                    flag_mismatch($sformatf("estimate angle %0d speed %0d with none pending",
                                            est_out.rotor_angle, est_out.rotor_speed));
                end else begin
                    want = expected_estimates.pop_front();
                    if (est_out.rotor_angle !== want.angle) begin
                        flag_mismatch($sformatf("estimate %0d: rotor_angle %0d, predicted %0d",
                                                results_seen, est_out.rotor_angle, want.angle));
                    end
                    if (est_out.rotor_speed !== want.speed) begin
                        flag_mismatch($sformatf("estimate %0d: rotor_speed %0d, predicted %0d",
                                                results_seen, est_out.rotor_speed, want.speed));
                    end
                    results_seen <= results_seen + 1;
                    // A long hold-off lets the block fill up and stall its input.
                    if (results_seen + 1 == LONG_STALL_AT) begin
                        stall_left = LONG_STALL_CYCLES;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                est_out.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = t_ready_mode'(2'($urandom_range(0, 3)));
                    mode_left  = $urandom_range(16, 96);
                end else begin
                    mode_left--;
                end
                case (ready_mode)
                    RDY_ALWAYS: est_out.ready <= 1'b1;
                    RDY_COIN:   est_out.ready <= 1'($urandom_range(0, 1));
                    RDY_SPARSE: est_out.ready <= ($urandom_range(0, 3) == 0);
                    default:    est_out.ready <= !est_out.ready;
                endcase
            end
        end
    end

    initial begin : sequencer
        logic [CFG_DATA_W-1:0] cfg_word;
        int                    n_items;
        hf_in.valid            = 1'b0;
        hf_in.hf_current_alpha = '0;
        hf_in.hf_current_beta  = '0;
        hf_in.speed_direction  = DIR_NONE;
        hf_in.polarity_flip    = 1'b0;
        est_out.ready          = 1'b0;
        reg_wr.valid           = 1'b0;
        reg_wr.index           = REG_PROP_GAIN;
        reg_wr.data            = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset gains: current extremes, every direction code, polarity flips.
        @(negedge i_clk);
        add_sample(0, 0, DIR_NONE, 1'b0);
        add_sample(32767, 32767, DIR_NONE, 1'b0);
        add_sample(-32768, -32768, DIR_NONE, 1'b0);
        add_sample(0, 32767, DIR_FWD, 1'b0);
        add_sample(0, -32768, DIR_FWD, 1'b0);
        add_sample(0, 32767, DIR_REV, 1'b0);
        add_sample(0, 32767, DIR_REV_ALT, 1'b0);
        add_sample(-32768, 0, DIR_NONE, 1'b1);
        add_sample(32767, -32768, DIR_REV, 1'b1);
        add_sample(21845, -10923, DIR_FWD, 1'b1);
        add_sample(-1, 1, DIR_NONE, 1'b0);
        add_sample(1, -1, DIR_REV_ALT, 1'b1);
        wait_idle();

        // Unknown index is ignored; full-scale gains and period saturate and wrap the angle.
        write_reg(REG_UNUSED, $urandom());
        write_reg(REG_PROP_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_INTEGRAL_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_STEP_TIME, 32'hFFFF_FFFF);
        @(negedge i_clk);
        add_sample(32767, -32768, DIR_NONE, 1'b0);
        add_sample(-32768, 32767, DIR_FWD, 1'b0);
        add_sample(-32768, -32768, DIR_REV, 1'b1);
        add_sample(32767, 32767, DIR_FWD, 1'b0);
        add_sample(0, -32768, DIR_FWD, 1'b1);
        add_sample(-32768, 0, DIR_REV_ALT, 1'b0);
        wait_idle();

        // A zero period freezes the integrator; the angle moves only by the half turn of a polarity flip.
        write_reg(REG_STEP_TIME, '0);
        @(negedge i_clk);
        add_sample(32767, 32767, DIR_NONE, 1'b0);
        add_sample(-32768, 12345, DIR_FWD, 1'b1);
        add_sample(0, 0, DIR_REV, 1'b0);
        add_sample(-32768, -32768, DIR_NONE, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            cfg_word = $urandom();
            cfg_word[GAIN_W-1:0] = (p == 0) ? 16'd550 : pick_gain();
            write_reg(REG_PROP_GAIN, cfg_word);
            cfg_word = $urandom();
            cfg_word[GAIN_W-1:0] = (p == 0) ? 16'd9000 : pick_gain();
            write_reg(REG_INTEGRAL_GAIN, cfg_word);
            case ($urandom_range(0, 5))
                0:       cfg_word = '0;
                1:       cfg_word = 32'd1;
                2:       cfg_word = '1;
                3:       cfg_word = $urandom();
                default: cfg_word = $urandom_range(20000, 2000000);
            endcase
            if (p == 0) begin
                cfg_word = 32'd214748;
            end
            write_reg(REG_STEP_TIME, cfg_word);
            if ($urandom_range(0, 2) == 0) begin
                write_reg(REG_UNUSED, $urandom());
            end
            n_items = (p == 0) ? 200 : 100;
            @(negedge i_clk);
            repeat (n_items) begin
                add_sample(pick_current(), pick_current(), DIR_W'($urandom_range(0, 3)),
                           ($urandom_range(0, 15) == 0));
            end
        end

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (expected_estimates.size() != 0) begin
            flag_mismatch($sformatf("%0d estimates never delivered", expected_estimates.size()));
        end
        if (mismatch_count == 0) begin
            $display("hfi_angle_tracking_pll_core regression: pass");
        end else begin
            $display("hfi_angle_tracking_pll_core regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("hfi_angle_tracking_pll_core regression: fail");
        $finish;
    end

endmodule
